// File: rtl/goal_approach_velocity_limiter_core_macros.svh
// assertion helpers for the core rtl file
`ifndef GOAL_APPROACH_VELOCITY_LIMITER_CORE_MACROS_SVH
`define GOAL_APPROACH_VELOCITY_LIMITER_CORE_MACROS_SVH

// checked only outside reset
`define GAV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked during reset as well
`define GAV_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/gav_pkg.sv
package gav_pkg;

  // goal offset width
  localparam int COORD_BITS = 16;

  // datapath widths
  localparam int MAG_W      = (COORD_BITS > 16) ? COORD_BITS : 16;
  localparam int RAD_W      = 2 * MAG_W;
  localparam int ROOT_W     = MAG_W + 8;
  localparam int PR_W       = ROOT_W + 16;
  localparam int SQ_PER     = 4;
  localparam int SQ_STAGES  = (ROOT_W + SQ_PER - 1) / SQ_PER;
  localparam int SQ_ITERS   = SQ_STAGES * SQ_PER;
  localparam int Y_W        = 2 * SQ_ITERS;
  localparam int REM_W      = SQ_ITERS + 3;
  localparam int CAP_W      = 15;
  localparam int M_W        = CAP_W + 8;
  localparam int NUM_W      = MAG_W + M_W;
  localparam int CMP_W      = NUM_W + 4;
  localparam int QW         = 18;
  localparam int DIV_PER    = 2;
  localparam int DIV_STAGES = QW / DIV_PER;
  localparam int LANES      = 3;
  localparam int NEAR_D2    = 100;

  // pipeline stage positions
  localparam int P_R1  = 0;
  localparam int P_R2  = 1;
  localparam int P_SQ  = 2;
  localparam int P_PR  = P_SQ + SQ_STAGES;
  localparam int P_MIN = P_PR + 1;
  localparam int P_NUM = P_MIN + 1;
  localparam int P_NF  = P_NUM + 1;
  localparam int P_DIV = P_NF + 1;
  localparam int P_OUT = P_DIV + DIV_STAGES;
  localparam int NST   = P_OUT + 1;

  // register reset values
  localparam logic [15:0]      APPROACH_ZONE_RST = 16'd1500;
  localparam logic [CAP_W-1:0] SPEED_CAP_RST     = 15'd500;
  localparam logic [15:0]      DIRECT_ZONE_RST   = 16'd500;
  localparam logic [15:0]      DIRECT_GAIN_RST   = 16'd256;

  typedef enum logic [1:0] {
    MODE_PASS   = 2'd0,
    MODE_CAP    = 2'd1,
    MODE_DIRECT = 2'd2
  } gav_mode_e;

  typedef enum logic [1:0] {
    REG_APPROACH_ZONE = 2'd0,
    REG_SPEED_CAP     = 2'd1,
    REG_DIRECT_ZONE   = 2'd2,
    REG_DIRECT_GAIN   = 2'd3
  } gav_reg_e;

  // per-word sideband carried down the pipe
  typedef struct packed {
    gav_mode_e                     mode;
    logic                          drv;  // aim at goal, quotient lanes 0 and 1
    logic                          scl;  // scale all three lanes
    logic signed [COORD_BITS-1:0]  dx;
    logic signed [COORD_BITS-1:0]  dy;
    logic signed [15:0]            vx;
    logic signed [15:0]            vy;
    logic signed [15:0]            wz;
  } gav_side_t;

  typedef struct packed {
    logic [Y_W-1:0]      y;
    logic [REM_W-1:0]    rem;
    logic [SQ_ITERS-1:0] root;
  } gav_sq_t;

  typedef struct packed {
    logic [CMP_W-1:0] rem;
    logic [QW-1:0]    q;
  } gav_dv_t;

  // SQ_PER digit-by-digit square root steps
  function automatic gav_sq_t gav_sqrt_step(gav_sq_t s);
    gav_sq_t          r;
    logic [REM_W-1:0] part;
    logic [REM_W-1:0] trial;
    r = s;
    for (int k = 0; k < SQ_PER; k++) begin
      part  = {r.rem[REM_W-3:0], r.y[Y_W-1 -: 2]};
      trial = {1'b0, r.root, 2'b01};
      r.y   = {r.y[Y_W-3:0], 2'b00};
      if (part >= trial) begin
        r.rem  = part - trial;
        r.root = {r.root[SQ_ITERS-2:0], 1'b1};
      end else begin
        r.rem  = part;
        r.root = {r.root[SQ_ITERS-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  // DIV_PER restoring division steps, quotient bits from bit_hi down
  function automatic gav_dv_t gav_div_step(gav_dv_t s, logic [ROOT_W:0] dv, int unsigned bit_hi);
    gav_dv_t          r;
    logic [CMP_W-1:0] sub;
    int unsigned      b;
    r = s;
    for (int k = 0; k < DIV_PER; k++) begin
      b   = bit_hi - k;
      sub = CMP_W'(dv) << b;
      if (r.rem >= sub) begin
        r.rem  = r.rem - sub;
        r.q[b] = 1'b1;
      end else begin
        r.q[b] = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic logic [MAG_W-1:0] gav_abs(logic signed [MAG_W-1:0] v);
    return v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);
  endfunction

  function automatic logic [15:0] gav_sat(logic signed [QW:0] v);
    if (v > 32767) begin
      return 16'h7fff;
    end else if (v < -32768) begin
      return 16'h8000;
    end else begin
      return v[15:0];
    end
  endfunction

endpackage

// File: rtl/gav_sqrt.sv
module gav_sqrt (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [gav_pkg::SQ_STAGES-1:0]        en_i,
  input  logic                                 valid_i,
  input  logic [gav_pkg::RAD_W-1:0]            rad_i,
  input  gav_pkg::gav_side_t                   side_i,
  output logic [gav_pkg::SQ_STAGES-1:0]        valid_o,
  output logic [gav_pkg::ROOT_W-1:0]           root_o,
  output gav_pkg::gav_side_t                   side_o
);

  gav_pkg::gav_sq_t   st_q   [gav_pkg::SQ_STAGES];
  gav_pkg::gav_side_t side_q [gav_pkg::SQ_STAGES];
  logic               v_q    [gav_pkg::SQ_STAGES];
  gav_pkg::gav_sq_t   entry;

  // radicand scaled by 2^16 so the root comes out in q.8
  always_comb begin
    entry.y    = gav_pkg::Y_W'(rad_i) << 16;
    entry.rem  = '0;
    entry.root = '0;
  end

  for (genvar s = 0; s < gav_pkg::SQ_STAGES; s++) begin : g_stage
    gav_pkg::gav_sq_t   st_in;
    gav_pkg::gav_side_t sd_in;
    logic               v_in;

    if (s == 0) begin : g_first
      assign st_in = entry;
      assign sd_in = side_i;
      assign v_in  = valid_i;
    end else begin : g_next
      assign st_in = st_q[s-1];
      assign sd_in = side_q[s-1];
      assign v_in  = v_q[s-1];
    end

    // stage valid
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i[s]) begin
        v_q[s] <= v_in;
      end
    end

    // root digits for this stage
    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        st_q[s]   <= gav_pkg::gav_sqrt_step(st_in);
        side_q[s] <= sd_in;
      end
    end

    assign valid_o[s] = v_q[s];
  end

  assign root_o = st_q[gav_pkg::SQ_STAGES-1].root[gav_pkg::ROOT_W-1:0];
  assign side_o = side_q[gav_pkg::SQ_STAGES-1];

endmodule

// File: rtl/gav_div.sv
module gav_div (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic [gav_pkg::DIV_STAGES-1:0]                    en_i,
  input  logic                                              valid_i,
  input  logic [gav_pkg::LANES-1:0][gav_pkg::CMP_W-1:0]     num_i,
  input  logic [gav_pkg::ROOT_W:0]                          dv_i,
  input  gav_pkg::gav_side_t                                side_i,
  output logic [gav_pkg::DIV_STAGES-1:0]                    valid_o,
  output logic [gav_pkg::LANES-1:0][gav_pkg::QW-1:0]        q_o,
  output gav_pkg::gav_side_t                                side_o
);

  gav_pkg::gav_dv_t [gav_pkg::LANES-1:0] st_q   [gav_pkg::DIV_STAGES];
  logic [gav_pkg::ROOT_W:0]              dv_q   [gav_pkg::DIV_STAGES];
  gav_pkg::gav_side_t                    side_q [gav_pkg::DIV_STAGES];
  logic                                  v_q    [gav_pkg::DIV_STAGES];
  gav_pkg::gav_dv_t [gav_pkg::LANES-1:0] entry;

  // dividends enter with an empty quotient
  always_comb begin
    for (int l = 0; l < gav_pkg::LANES; l++) begin
      entry[l].rem = num_i[l];
      entry[l].q   = '0;
    end
  end

  for (genvar s = 0; s < gav_pkg::DIV_STAGES; s++) begin : g_stage
    gav_pkg::gav_dv_t [gav_pkg::LANES-1:0] st_in;
    gav_pkg::gav_dv_t [gav_pkg::LANES-1:0] st_nx;
    logic [gav_pkg::ROOT_W:0]              dv_in;
    gav_pkg::gav_side_t                    sd_in;
    logic                                  v_in;

    if (s == 0) begin : g_first
      assign st_in = entry;
      assign dv_in = dv_i;
      assign sd_in = side_i;
      assign v_in  = valid_i;
    end else begin : g_next
      assign st_in = st_q[s-1];
      assign dv_in = dv_q[s-1];
      assign sd_in = side_q[s-1];
      assign v_in  = v_q[s-1];
    end

    // quotient bits of this stage, all lanes share the divisor
    always_comb begin
      for (int l = 0; l < gav_pkg::LANES; l++) begin
        st_nx[l] = gav_pkg::gav_div_step(st_in[l], dv_in,
                                         gav_pkg::QW - 1 - s * gav_pkg::DIV_PER);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i[s]) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        st_q[s]   <= st_nx;
        dv_q[s]   <= dv_in;
        side_q[s] <= sd_in;
      end
    end

    assign valid_o[s] = v_q[s];
  end

  always_comb begin
    for (int l = 0; l < gav_pkg::LANES; l++) begin
      q_o[l] = st_q[gav_pkg::DIV_STAGES-1][l].q;
    end
  end

  assign side_o = side_q[gav_pkg::DIV_STAGES-1];

endmodule

// File: rtl/goal_approach_velocity_limiter_core.sv
// goal approach velocity limiter
// input channel (in_valid_i / in_ready_o): one word holds the goal offset,
// the goal-known flag and the upstream velocity command. output channel
// (out_valid_o / out_ready_i): one word per input word, in order, with the
// limited command and the zone mode.
// stages from acceptance to out_valid_o with 16-bit coordinates
// (2 square/compare stages, 6 square-root stages at 4 digits each, 4 scaling
// stages, 9 divider stages at 2 quotient bits each, 1 output register).
// throughput: one word per cycle while the receiver is ready; every stage is one register deep and the
// slowest stage is four dependent compare/subtract steps in the square root.
// each stage moves on when its successor is empty or moving, so bubbles
// close up; when the receiver stalls the pipe fills and in_ready_o falls
// only once every stage holds a word. nothing is dropped or repeated.
// the register port (cfg_we_i, cfg_idx_i, cfg_data_i) is to be written by the user
// only while no word is in flight; the block itself does not enforce this.
// reset clears every stage valid and loads the register defaults: approach
// zone 1500 mm, speed cap 500 mm/s, direct zone 500 mm, gain 1.0 in q8.8.
`include "goal_approach_velocity_limiter_core_macros.svh"

module goal_approach_velocity_limiter_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [1:0]                             cfg_idx_i,
  input  logic [15:0]                            cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic                                   goal_known_i,
  input  logic signed [gav_pkg::COORD_BITS-1:0]  goal_dx_i,
  input  logic signed [gav_pkg::COORD_BITS-1:0]  goal_dy_i,
  input  logic signed [15:0]                     cmd_vx_i,
  input  logic signed [15:0]                     cmd_vy_i,
  input  logic signed [15:0]                     cmd_wz_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [15:0]                     out_vx_o,
  output logic signed [15:0]                     out_vy_o,
  output logic signed [15:0]                     out_wz_o,
  output logic [1:0]                             zone_mode_o
);

  localparam int MAG_W = gav_pkg::MAG_W;
  localparam int RAD_W = gav_pkg::RAD_W;
  localparam int ROOT_W = gav_pkg::ROOT_W;
  localparam int PR_W = gav_pkg::PR_W;
  localparam int M_W = gav_pkg::M_W;
  localparam int NUM_W = gav_pkg::NUM_W;
  localparam int CMP_W = gav_pkg::CMP_W;
  localparam int QW = gav_pkg::QW;
  localparam int LANES = gav_pkg::LANES;

  // configuration registers
  logic [15:0]               az_q, dz_q, gain_q;
  logic [gav_pkg::CAP_W-1:0] cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      az_q   <= gav_pkg::APPROACH_ZONE_RST;
      cap_q  <= gav_pkg::SPEED_CAP_RST;
      dz_q   <= gav_pkg::DIRECT_ZONE_RST;
      gain_q <= gav_pkg::DIRECT_GAIN_RST;
    end else if (cfg_we_i) begin
      case (gav_pkg::gav_reg_e'(cfg_idx_i))
        gav_pkg::REG_APPROACH_ZONE: az_q   <= cfg_data_i;
        gav_pkg::REG_SPEED_CAP:     cap_q  <= cfg_data_i[gav_pkg::CAP_W-1:0];
        gav_pkg::REG_DIRECT_ZONE:   dz_q   <= cfg_data_i;
        gav_pkg::REG_DIRECT_GAIN:   gain_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage enables: a stage loads when it is empty or its word moves on
  logic [gav_pkg::NST-1:0] vld, en;

  always_comb begin
    en[gav_pkg::NST-1] = !vld[gav_pkg::NST-1] || out_ready_i;
    for (int k = gav_pkg::NST - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_ready_o = en[gav_pkg::P_R1];

  // stage 1: magnitudes and squares
  logic                 r1_v_q, r1_known_q;
  gav_pkg::gav_side_t   r1_side_q, r1_side_d;
  logic [RAD_W-1:0]     r1_dx2_q, r1_dy2_q, r1_vx2_q, r1_vy2_q;
  logic [31:0]          r1_dz2_q, r1_az2_q;
  logic [2*gav_pkg::CAP_W-1:0] r1_cap2_q;
  logic [MAG_W-1:0]     in_mdx, in_mdy, in_mvx, in_mvy;

  always_comb begin
    in_mdx = gav_pkg::gav_abs(MAG_W'(goal_dx_i));
    in_mdy = gav_pkg::gav_abs(MAG_W'(goal_dy_i));
    in_mvx = gav_pkg::gav_abs(MAG_W'(cmd_vx_i));
    in_mvy = gav_pkg::gav_abs(MAG_W'(cmd_vy_i));
    r1_side_d      = '0;
    r1_side_d.mode = gav_pkg::MODE_PASS;
    r1_side_d.dx   = goal_dx_i;
    r1_side_d.dy   = goal_dy_i;
    r1_side_d.vx   = cmd_vx_i;
    r1_side_d.vy   = cmd_vy_i;
    r1_side_d.wz   = cmd_wz_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_v_q <= 1'b0;
    end else if (en[gav_pkg::P_R1]) begin
      r1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[gav_pkg::P_R1]) begin
      r1_known_q <= goal_known_i;
      r1_side_q  <= r1_side_d;
      r1_dx2_q   <= RAD_W'(in_mdx) * RAD_W'(in_mdx);
      r1_dy2_q   <= RAD_W'(in_mdy) * RAD_W'(in_mdy);
      r1_vx2_q   <= RAD_W'(in_mvx) * RAD_W'(in_mvx);
      r1_vy2_q   <= RAD_W'(in_mvy) * RAD_W'(in_mvy);
      r1_dz2_q   <= 32'(dz_q) * 32'(dz_q);
      r1_az2_q   <= 32'(az_q) * 32'(az_q);
      r1_cap2_q  <= (2*gav_pkg::CAP_W)'(cap_q) * (2*gav_pkg::CAP_W)'(cap_q);
    end
  end

  // stage 2: sums, zone decision, radicand select
  logic               r2_v_q;
  gav_pkg::gav_side_t r2_side_q, r2_side_d;
  logic [RAD_W-1:0]   r2_rad_q, r2_rad_d;
  logic [RAD_W-1:0]   d2, s2;
  logic               in_dz, in_az, near, over;

  always_comb begin
    d2    = r1_dx2_q + r1_dy2_q;
    s2    = r1_vx2_q + r1_vy2_q;
    in_dz = d2 < RAD_W'(r1_dz2_q);
    in_az = d2 < RAD_W'(r1_az2_q);
    near  = d2 <= RAD_W'(gav_pkg::NEAR_D2);
    over  = s2 > RAD_W'(r1_cap2_q);
    r2_side_d     = r1_side_q;
    r2_side_d.drv = r1_known_q && in_dz && !near;
    r2_side_d.scl = r1_known_q && !in_dz && in_az && over;
    if (!r1_known_q) begin
      r2_side_d.mode = gav_pkg::MODE_PASS;
    end else if (in_dz) begin
      r2_side_d.mode = gav_pkg::MODE_DIRECT;
    end else if (in_az) begin
      r2_side_d.mode = gav_pkg::MODE_CAP;
    end else begin
      r2_side_d.mode = gav_pkg::MODE_PASS;
    end
    r2_rad_d = r2_side_d.drv ? d2 : s2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r2_v_q <= 1'b0;
    end else if (en[gav_pkg::P_R2]) begin
      r2_v_q <= r1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[gav_pkg::P_R2]) begin
      r2_side_q <= r2_side_d;
      r2_rad_q  <= r2_rad_d;
    end
  end

  // square root of the distance or the planar speed, q.8
  logic [gav_pkg::SQ_STAGES-1:0] sq_vld;
  logic [ROOT_W-1:0]             sq_root;
  gav_pkg::gav_side_t            sq_side;

  gav_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en[gav_pkg::P_SQ +: gav_pkg::SQ_STAGES]),
    .valid_i (r2_v_q),
    .rad_i   (r2_rad_q),
    .side_i  (r2_side_q),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // root times gain (distance times gain when aiming at the goal)
  logic               pr_v_q;
  gav_pkg::gav_side_t pr_side_q;
  logic [PR_W-1:0]    pr_prod_q;
  logic [ROOT_W-1:0]  pr_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pr_v_q <= 1'b0;
    end else if (en[gav_pkg::P_PR]) begin
      pr_v_q <= sq_vld[gav_pkg::SQ_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[gav_pkg::P_PR]) begin
      pr_side_q <= sq_side;
      pr_prod_q <= PR_W'(sq_root) * PR_W'(gain_q);
      pr_den_q  <= sq_root;
    end
  end

  // target speed, capped, q.8
  logic               mn_v_q;
  gav_pkg::gav_side_t mn_side_q;
  logic [M_W-1:0]     mn_m_q, mn_m_d, capq;
  logic [ROOT_W-1:0]  mn_den_q;
  logic [PR_W-9:0]    tgt;

  always_comb begin
    tgt  = pr_prod_q[PR_W-1:8];
    capq = {cap_q, 8'h00};
    if (pr_side_q.drv && (tgt < (PR_W-8)'(capq))) begin
      mn_m_d = tgt[M_W-1:0];
    end else begin
      mn_m_d = capq;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mn_v_q <= 1'b0;
    end else if (en[gav_pkg::P_MIN]) begin
      mn_v_q <= pr_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[gav_pkg::P_MIN]) begin
      mn_side_q <= pr_side_q;
      mn_m_q    <= mn_m_d;
      mn_den_q  <= pr_den_q;
    end
  end

  // lane products
  logic                               nu_v_q;
  gav_pkg::gav_side_t                 nu_side_q;
  logic [LANES-1:0][NUM_W-1:0]        nu_num_q;
  logic [ROOT_W-1:0]                  nu_den_q;
  logic [LANES-1:0][MAG_W-1:0]        lane_mag;

  always_comb begin
    lane_mag[0] = mn_side_q.drv ? gav_pkg::gav_abs(MAG_W'(mn_side_q.dx))
                                : gav_pkg::gav_abs(MAG_W'(mn_side_q.vx));
    lane_mag[1] = mn_side_q.drv ? gav_pkg::gav_abs(MAG_W'(mn_side_q.dy))
                                : gav_pkg::gav_abs(MAG_W'(mn_side_q.vy));
    lane_mag[2] = gav_pkg::gav_abs(MAG_W'(mn_side_q.wz));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nu_v_q <= 1'b0;
    end else if (en[gav_pkg::P_NUM]) begin
      nu_v_q <= mn_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[gav_pkg::P_NUM]) begin
      nu_side_q <= mn_side_q;
      nu_den_q  <= mn_den_q;
      for (int l = 0; l < LANES; l++) begin
        nu_num_q[l] <= NUM_W'(lane_mag[l]) * NUM_W'(mn_m_q);
      end
    end
  end

  // rounding dividends 2*num + den over divisor 2*den
  logic                           nf_v_q;
  gav_pkg::gav_side_t             nf_side_q;
  logic [LANES-1:0][CMP_W-1:0]    nf_num_q;
  logic [ROOT_W:0]                nf_dv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nf_v_q <= 1'b0;
    end else if (en[gav_pkg::P_NF]) begin
      nf_v_q <= nu_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[gav_pkg::P_NF]) begin
      nf_side_q <= nu_side_q;
      nf_dv_q   <= {nu_den_q, 1'b0};
      for (int l = 0; l < LANES; l++) begin
        nf_num_q[l] <= CMP_W'({nu_num_q[l], 1'b0}) + CMP_W'(nu_den_q);
      end
    end
  end

  // three-lane divider
  logic [gav_pkg::DIV_STAGES-1:0] dv_vld;
  logic [LANES-1:0][QW-1:0]       dv_q;
  gav_pkg::gav_side_t             div_side;

  gav_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en[gav_pkg::P_DIV +: gav_pkg::DIV_STAGES]),
    .valid_i (nf_v_q),
    .num_i   (nf_num_q),
    .dv_i    (nf_dv_q),
    .side_i  (nf_side_q),
    .valid_o (dv_vld),
    .q_o     (dv_q),
    .side_o  (div_side)
  );

  // sign, saturate and pick the final command
  logic                     out_v_q;
  logic signed [15:0]       out_vx_q, out_vy_q, out_wz_q, out_vx_d, out_vy_d, out_wz_d;
  logic [1:0]               out_mode_q;
  logic [LANES-1:0]         neg;
  logic signed [QW:0]       lane_val [LANES];

  always_comb begin
    neg[0] = div_side.drv ? div_side.dx[gav_pkg::COORD_BITS-1] : div_side.vx[15];
    neg[1] = div_side.drv ? div_side.dy[gav_pkg::COORD_BITS-1] : div_side.vy[15];
    neg[2] = div_side.wz[15];
    for (int l = 0; l < LANES; l++) begin
      lane_val[l] = neg[l] ? -signed'({1'b0, dv_q[l]}) : signed'({1'b0, dv_q[l]});
    end
    out_vx_d = div_side.vx;
    out_vy_d = div_side.vy;
    out_wz_d = div_side.wz;
    if (div_side.drv || div_side.scl) begin
      out_vx_d = gav_pkg::gav_sat(lane_val[0]);
      out_vy_d = gav_pkg::gav_sat(lane_val[1]);
    end else if (div_side.mode == gav_pkg::MODE_DIRECT) begin
      // goal reached: stop planar motion
      out_vx_d = '0;
      out_vy_d = '0;
    end
    if (div_side.scl) begin
      out_wz_d = gav_pkg::gav_sat(lane_val[2]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en[gav_pkg::P_OUT]) begin
      out_v_q <= dv_vld[gav_pkg::DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[gav_pkg::P_OUT]) begin
      out_vx_q   <= out_vx_d;
      out_vy_q   <= out_vy_d;
      out_wz_q   <= out_wz_d;
      out_mode_q <= div_side.mode;
    end
  end

  // stage valid vector
  always_comb begin
    vld[gav_pkg::P_R1]                          = r1_v_q;
    vld[gav_pkg::P_R2]                          = r2_v_q;
    vld[gav_pkg::P_SQ +: gav_pkg::SQ_STAGES]    = sq_vld;
    vld[gav_pkg::P_PR]                          = pr_v_q;
    vld[gav_pkg::P_MIN]                         = mn_v_q;
    vld[gav_pkg::P_NUM]                         = nu_v_q;
    vld[gav_pkg::P_NF]                          = nf_v_q;
    vld[gav_pkg::P_DIV +: gav_pkg::DIV_STAGES]  = dv_vld;
    vld[gav_pkg::P_OUT]                         = out_v_q;
  end

  assign out_valid_o = out_v_q;
  assign out_vx_o    = out_vx_q;
  assign out_vy_o    = out_vy_q;
  assign out_wz_o    = out_wz_q;
  assign zone_mode_o = out_mode_q;

  // input back-pressure only comes from a stalled receiver on a full pipe
  `GAV_ASSERT(a_stall_source, !in_ready_o |-> (out_valid_o && !out_ready_i), "input stalled without output stall")
  // pass-through words leave the command untouched
  `GAV_ASSERT(a_pass_keeps, (en[gav_pkg::P_OUT] && dv_vld[gav_pkg::DIV_STAGES-1] && div_side.mode == gav_pkg::MODE_PASS) |=> (out_vx_o == $past(div_side.vx) && out_vy_o == $past(div_side.vy) && out_wz_o == $past(div_side.wz)), "pass-through word altered")
  // no word leaves while in reset
  `GAV_ASSERT_RST(a_rst_empty, !rst_ni |-> !out_valid_o, "output valid during reset")

endmodule
